>>> hw/rtl/psmqr_pkg.sv
// ----------------------------------------------------------------------------
// psmqr_pkg: shared definitions for the publish/subscribe queue router
// Command and status codes, default sizes, controller states and the
// command/status bundles exchanged between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package psmqr_pkg;

    // Default sizes of the router.
    localparam int P_NUM_PIPES   = 10;
    localparam int P_ROUTE_SLOTS = 10;
    localparam int P_NUM_MSG_IDS = 20;
    localparam int P_QUEUE_DEPTH = 5;
    localparam int P_MSG_SLOTS   = 64;

    // Fixed field widths.
    localparam int CMD_W = 3;
    localparam int SUB_W = 4;
    localparam int ID_W  = 5;
    localparam int HDL_W = 6;
    localparam int ST_W  = 3;
    localparam int DLV_W = 4;

    // Request command codes.
    localparam logic [CMD_W-1:0] CMD_SUBSCRIBE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNSUBSCRIBE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUBLISH     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RECEIVE     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RELEASE     = 3'd5;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_READY = 3'd1;
    localparam logic [ST_W-1:0] ST_INVALID   = 3'd2;
    localparam logic [ST_W-1:0] ST_RANGE     = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [ST_W-1:0] ST_BUSY      = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_DECODE,
        S_SCAN,
        S_SUB_WR,
        S_PUB_WR,
        S_RX_RD,
        S_RX_REF,
        S_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic            load_in;
        logic            scan_start;
        logic            scan_run;
        logic            sub_write;
        logic            unsub_clear;
        logic            enqueue;
        logic            pub_wb;
        logic            pop;
        logic            ref_sel_pop;
        logic            ref_dec;
        logic            flush;
        logic            set_status;
        logic [ST_W-1:0] status;
        logic            out_load;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic             bus_en;
        logic [CMD_W-1:0] cmd;
        logic             sub_ok;
        logic             id_ok;
        logic             h_ok;
        logic             cnt_full;
        logic             cnt_zero;
        logic             q_active;
        logic             q_empty;
        logic             ref_nz;
        logic             ev_vld;
        logic             ev_last;
        logic             ev_match;
        logic             ev_deliver;
        logic             have_empty;
        logic             n_zero;
        logic             out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hw/rtl/pubsub_multicast_queue_router_core.sv
// ----------------------------------------------------------------------------
// pubsub_multicast_queue_router_core: publish/subscribe queue router
// Routes message handles from topic ids to subscriber ring queues and keeps
// a reference count per handle.
// ----------------------------------------------------------------------------
// Sequencing: flush, release and rejected requests pass through load, decode and
// output; receive adds a queue read and a reference update; subscribe,
// unsubscribe and publish scan up to ROUTE_SLOTS route slots, and subscribe or publish may then write back.
// Throughput: one request at a time; the route scan reads one table slot per
// cycle from the route memory.
// Reset (synchronous, active low) clears all routes, queues, counts and sets
// the bus enable register to 1; no clearing pass is needed.
`default_nettype none

module pubsub_multicast_queue_router_core #(
    parameter int NUM_PIPES   = psmqr_pkg::P_NUM_PIPES,
    parameter int ROUTE_SLOTS = psmqr_pkg::P_ROUTE_SLOTS,
    parameter int NUM_MSG_IDS = psmqr_pkg::P_NUM_MSG_IDS,
    parameter int QUEUE_DEPTH = psmqr_pkg::P_QUEUE_DEPTH,
    parameter int MSG_SLOTS   = psmqr_pkg::P_MSG_SLOTS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Request channel.
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [psmqr_pkg::CMD_W-1:0] i_cmd,
    input  wire logic [psmqr_pkg::SUB_W-1:0] i_subscriber_id,
    input  wire logic [psmqr_pkg::ID_W-1:0]  i_message_id,
    input  wire logic [psmqr_pkg::HDL_W-1:0] i_msg_handle,
    // Result channel.
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [psmqr_pkg::ST_W-1:0]       o_status,
    output logic [psmqr_pkg::HDL_W-1:0]      o_out_handle,
    output logic [psmqr_pkg::DLV_W-1:0]      o_deliveries,
    // Bus enable register write.
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic                        i_cfg_data
);
    import psmqr_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_busy;

    // The request side is open only while the sequencer is idle. A finished
    // result sits in the output register, so the next request can be taken
    // while the previous result still waits on a stalled consumer.
    assign o_stall = w_busy;

    // The enable register is a plain flop and accepts a write every cycle.
    assign o_cfg_ready = 1'b1;

    psmqr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_busy  (w_busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // The datapath holds the route table (memory plus per-slot valid bits),
    // the per-subscriber ring queues and the per-handle reference counts.
    psmqr_dp #(
        .NUM_PIPES   (NUM_PIPES),
        .ROUTE_SLOTS (ROUTE_SLOTS),
        .NUM_MSG_IDS (NUM_MSG_IDS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MSG_SLOTS   (MSG_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (i_cmd),
        .i_subscriber_id (i_subscriber_id),
        .i_message_id    (i_message_id),
        .i_msg_handle    (i_msg_handle),
        .i_cfg_wr        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_stall         (i_stall),
        .i_dcmd          (w_cmd),
        .o_sts           (w_sts),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_out_handle    (o_out_handle),
        .o_deliveries    (o_deliveries)
    );

endmodule

`default_nettype wire

>>> hw/rtl/psmqr_ctrl.sv
// ----------------------------------------------------------------------------
// psmqr_ctrl: request sequencer of the queue router
// Walks each request through decode, route scan and write-back steps and
// drives the datapath with one command bundle per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module psmqr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_busy,
    input  wire psmqr_pkg::t_dp_sts i_sts,
    output psmqr_pkg::t_dp_cmd      o_cmd
);
    import psmqr_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd w_cmd;
    logic    w_rx_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: n_state = S_DECODE;
            S_DECODE: begin
                if (w_cmd.scan_start) begin
                    n_state = S_SCAN;
                end else if (w_rx_go) begin
                    n_state = S_RX_RD;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SCAN: begin
                if (i_sts.ev_vld) begin
                    if (i_sts.cmd == CMD_PUBLISH) begin
                        if (i_sts.ev_last) begin
                            n_state = S_PUB_WR;
                        end
                    end else if (i_sts.ev_match) begin
                        n_state = S_OUT;
                    end else if (i_sts.ev_last) begin
                        n_state = (i_sts.cmd == CMD_SUBSCRIBE) ? S_SUB_WR : S_OUT;
                    end
                end
            end
            S_SUB_WR: n_state = S_OUT;
            S_PUB_WR: n_state = S_OUT;
            S_RX_RD:  n_state = S_RX_REF;
            S_RX_REF: n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_cmd   = '0;
        w_rx_go = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_cmd.load_in = i_valid;
            end
            S_DECODE: begin
                w_cmd.set_status = 1'b1;
                w_cmd.status     = ST_INVALID;
                if (!i_sts.bus_en) begin
                    w_cmd.status = ST_NOT_READY;
                end else begin
                    case (i_sts.cmd)
                        CMD_SUBSCRIBE: begin
                            if (i_sts.sub_ok && i_sts.id_ok) begin
                                if (i_sts.cnt_full) begin
                                    w_cmd.status = ST_RANGE;
                                end else begin
                                    w_cmd.set_status = 1'b0;
                                    w_cmd.scan_start = 1'b1;
                                end
                            end
                        end
                        CMD_UNSUBSCRIBE: begin
                            if (i_sts.sub_ok && i_sts.id_ok) begin
                                if (i_sts.cnt_zero) begin
                                    w_cmd.status = ST_NOT_FOUND;
                                end else begin
                                    w_cmd.set_status = 1'b0;
                                    w_cmd.scan_start = 1'b1;
                                end
                            end
                        end
                        CMD_PUBLISH: begin
                            if (i_sts.id_ok && i_sts.h_ok) begin
                                w_cmd.set_status = 1'b0;
                                w_cmd.scan_start = 1'b1;
                            end
                        end
                        CMD_RECEIVE: begin
                            if (i_sts.sub_ok) begin
                                if (!i_sts.q_active || i_sts.q_empty) begin
                                    w_cmd.status = ST_RANGE;
                                end else begin
                                    w_cmd.set_status = 1'b0;
                                    w_rx_go          = 1'b1;
                                end
                            end
                        end
                        CMD_FLUSH: begin
                            if (i_sts.sub_ok) begin
                                w_cmd.flush  = 1'b1;
                                w_cmd.status = ST_OK;
                            end
                        end
                        CMD_RELEASE: begin
                            if (i_sts.h_ok) begin
                                w_cmd.status = i_sts.ref_nz ? ST_BUSY : ST_OK;
                            end
                        end
                        default: w_cmd.status = ST_INVALID;
                    endcase
                end
            end
            S_SCAN: begin
                w_cmd.scan_run = 1'b1;
                if (i_sts.ev_vld) begin
                    if (i_sts.cmd == CMD_PUBLISH) begin
                        w_cmd.enqueue = i_sts.ev_deliver;
                    end else if (i_sts.ev_match) begin
                        w_cmd.unsub_clear = (i_sts.cmd == CMD_UNSUBSCRIBE);
                        w_cmd.set_status  = 1'b1;
                        w_cmd.status      = ST_OK;
                    end else if (i_sts.ev_last && i_sts.cmd == CMD_UNSUBSCRIBE) begin
                        w_cmd.set_status = 1'b1;
                        w_cmd.status     = ST_NOT_FOUND;
                    end
                end
            end
            S_SUB_WR: begin
                w_cmd.sub_write  = i_sts.have_empty;
                w_cmd.set_status = 1'b1;
                w_cmd.status     = i_sts.have_empty ? ST_OK : ST_RANGE;
            end
            S_PUB_WR: begin
                w_cmd.pub_wb     = 1'b1;
                w_cmd.set_status = 1'b1;
                w_cmd.status     = i_sts.n_zero ? ST_RANGE : ST_OK;
            end
            S_RX_RD: begin
                w_cmd.pop         = 1'b1;
                w_cmd.ref_sel_pop = 1'b1;
            end
            S_RX_REF: begin
                w_cmd.ref_dec    = 1'b1;
                w_cmd.set_status = 1'b1;
                w_cmd.status     = ST_OK;
            end
            S_OUT: begin
                w_cmd.out_load = i_sts.out_free;
            end
            default: w_cmd = '0;
        endcase
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/psmqr_dp.sv
// ----------------------------------------------------------------------------
// psmqr_dp: storage and arithmetic of the queue router
// Holds the route table, subscriber queues, reference counts, the enable
// register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module psmqr_dp #(
    parameter int NUM_PIPES   = psmqr_pkg::P_NUM_PIPES,
    parameter int ROUTE_SLOTS = psmqr_pkg::P_ROUTE_SLOTS,
    parameter int NUM_MSG_IDS = psmqr_pkg::P_NUM_MSG_IDS,
    parameter int QUEUE_DEPTH = psmqr_pkg::P_QUEUE_DEPTH,
    parameter int MSG_SLOTS   = psmqr_pkg::P_MSG_SLOTS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [psmqr_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic [psmqr_pkg::SUB_W-1:0]   i_subscriber_id,
    input  wire logic [psmqr_pkg::ID_W-1:0]    i_message_id,
    input  wire logic [psmqr_pkg::HDL_W-1:0]   i_msg_handle,
    input  wire logic                          i_cfg_wr,
    input  wire logic                          i_cfg_data,
    input  wire logic                          i_stall,
    input  wire psmqr_pkg::t_dp_cmd            i_dcmd,
    output psmqr_pkg::t_dp_sts                 o_sts,
    output logic                               o_valid,
    output logic [psmqr_pkg::ST_W-1:0]         o_status,
    output logic [psmqr_pkg::HDL_W-1:0]        o_out_handle,
    output logic [psmqr_pkg::DLV_W-1:0]        o_deliveries
);
    import psmqr_pkg::*;

    localparam int PW   = $clog2(NUM_PIPES);
    localparam int IW   = (NUM_MSG_IDS > 1) ? $clog2(NUM_MSG_IDS) : 1;
    localparam int SIW  = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
    localparam int SCW  = $clog2(ROUTE_SLOTS + 1);
    localparam int RDEP = NUM_MSG_IDS * ROUTE_SLOTS;
    localparam int AW   = (RDEP > 1) ? $clog2(RDEP) : 1;
    localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW   = $clog2(QUEUE_DEPTH + 1);
    localparam int QDEP = NUM_PIPES << QW;
    localparam int HW   = $clog2(MSG_SLOTS);
    localparam int REFW = 6;

    localparam logic [SIW-1:0]  LAST_SLOT = SIW'(ROUTE_SLOTS - 1);
    localparam logic [SCW-1:0]  SLOTS_C   = SCW'(ROUTE_SLOTS);
    localparam logic [FW-1:0]   DEPTH_C   = FW'(QUEUE_DEPTH);
    localparam logic [QW-1:0]   LAST_QPOS = QW'(QUEUE_DEPTH - 1);
    localparam logic [REFW-1:0] REF_MAX   = '1;
    localparam logic [DLV_W-1:0] DLV_MAX  = '1;

    // Request fields and result.
    logic [CMD_W-1:0] r_cmd;
    logic [SUB_W-1:0] r_sub;
    logic [ID_W-1:0]  r_id;
    logic [HDL_W-1:0] r_h;
    logic [ST_W-1:0]  r_status;
    logic [HDL_W-1:0] r_ohdl;
    logic [DLV_W-1:0] r_dlv;
    logic             r_bus_en;

    // Output register.
    logic             r_ovalid;
    logic [ST_W-1:0]  r_o_status;
    logic [HDL_W-1:0] r_o_hdl;
    logic [DLV_W-1:0] r_o_dlv;

    // Route table.
    logic [SUB_W-1:0] r_rt_mem [RDEP];
    logic             r_rt_vld [RDEP];
    logic [SCW-1:0]   r_rt_cnt [NUM_MSG_IDS];

    // Scan state.
    logic [SCW-1:0]   r_idx;
    logic             r_rd_vld;
    logic [SIW-1:0]   r_rd_slot;
    logic             r_rd_valid;
    logic [SUB_W-1:0] r_rd_pipe;
    logic [SIW-1:0]   r_last_empty;
    logic             r_have_empty;
    logic [DLV_W-1:0] r_n;
    logic [REFW-1:0]  r_ref_acc;

    // Subscriber queues.
    logic [HDL_W-1:0] r_q_mem  [QDEP];
    logic [HDL_W-1:0] r_q_rd;
    logic [QW-1:0]    r_head   [NUM_PIPES];
    logic [QW-1:0]    r_tail   [NUM_PIPES];
    logic [FW-1:0]    r_fill   [NUM_PIPES];
    logic             r_active [NUM_PIPES];

    // Reference counts.
    logic [REFW-1:0]  r_ref_mem [MSG_SLOTS];
    logic             r_ref_vld [MSG_SLOTS];
    logic [REFW-1:0]  r_ref_q;
    logic             r_ref_vq;

    logic             w_sub_ok;
    logic             w_id_ok;
    logic             w_h_ok;
    logic [PW-1:0]    w_sidx;
    logic [IW-1:0]    w_iidx;
    logic [PW-1:0]    w_qidx;
    logic             w_p_ok;
    logic             w_deliver;
    logic             w_match;
    logic             w_issue;
    logic [AW-1:0]    w_id_base;
    logic [AW-1:0]    w_rd_addr;
    logic [AW-1:0]    w_wr_addr;
    logic [REFW-1:0]  w_ref_val;
    logic [HW-1:0]    w_ref_raddr;
    logic             w_pop_ok;
    logic             w_out_free;

    assign w_sub_ok  = (5'(r_sub) < 5'(NUM_PIPES));
    assign w_id_ok   = (6'(r_id) < 6'(NUM_MSG_IDS));
    assign w_h_ok    = (7'(r_h) < 7'(MSG_SLOTS));
    assign w_sidx    = r_sub[PW-1:0];
    assign w_iidx    = r_id[IW-1:0];
    assign w_qidx    = i_dcmd.scan_run ? r_rd_pipe[PW-1:0] : w_sidx;
    assign w_p_ok    = (5'(r_rd_pipe) < 5'(NUM_PIPES));
    assign w_deliver = r_rd_valid && w_p_ok && r_active[w_qidx]
                       && (r_fill[w_qidx] < DEPTH_C);
    assign w_match   = r_rd_valid && (r_rd_pipe == r_sub);
    assign w_issue   = i_dcmd.scan_run && (r_idx < SLOTS_C);
    assign w_id_base = AW'(w_iidx) * AW'(ROUTE_SLOTS);
    assign w_rd_addr = w_id_base + AW'(r_idx[SIW-1:0]);
    assign w_wr_addr = w_id_base + AW'(i_dcmd.sub_write ? r_last_empty : r_rd_slot);
    assign w_ref_val = r_ref_vq ? r_ref_q : '0;
    assign w_ref_raddr = i_dcmd.ref_sel_pop ? r_q_rd[HW-1:0] : r_h[HW-1:0];
    assign w_pop_ok  = (7'(r_ohdl) < 7'(MSG_SLOTS));
    assign w_out_free = !r_ovalid || !i_stall;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_en <= 1'b1;
            r_ovalid <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_bus_en <= i_cfg_data;
            end
            if (i_dcmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            r_rd_vld <= w_issue;
        end
    end

    // Request fields, scan bookkeeping and result payload.
    always_ff @(posedge i_clk) begin
        if (i_dcmd.load_in) begin
            r_cmd  <= i_cmd;
            r_sub  <= i_subscriber_id;
            r_id   <= i_message_id;
            r_h    <= i_msg_handle;
            r_ohdl <= '0;
            r_dlv  <= '0;
        end
        if (i_dcmd.set_status) begin
            r_status <= i_dcmd.status;
        end
        if (i_dcmd.scan_start) begin
            r_idx        <= '0;
            r_have_empty <= 1'b0;
            r_n          <= '0;
            r_ref_acc    <= w_ref_val;
        end else if (w_issue) begin
            r_idx <= r_idx + SCW'(1);
        end
        if (w_issue) begin
            r_rd_slot  <= r_idx[SIW-1:0];
            r_rd_valid <= r_rt_vld[w_rd_addr];
            r_rd_pipe  <= r_rt_mem[w_rd_addr];
        end
        if (i_dcmd.scan_run && r_rd_vld && !r_rd_valid) begin
            r_last_empty <= r_rd_slot;
            r_have_empty <= 1'b1;
        end
        if (i_dcmd.enqueue) begin
            r_n <= (r_n == DLV_MAX) ? DLV_MAX : r_n + DLV_W'(1);
            r_ref_acc <= (r_ref_acc == REF_MAX) ? REF_MAX : r_ref_acc + REFW'(1);
        end
        if (i_dcmd.pub_wb) begin
            r_dlv <= r_n;
        end
        if (i_dcmd.pop) begin
            r_ohdl <= r_q_rd;
        end
        if (i_dcmd.out_load) begin
            r_o_status <= r_status;
            r_o_hdl    <= r_ohdl;
            r_o_dlv    <= r_dlv;
        end
    end

    // Route table memory: one read and one write per cycle.
    always_ff @(posedge i_clk) begin
        if (i_dcmd.sub_write) begin
            r_rt_mem[w_wr_addr] <= r_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RDEP; k++) begin
                r_rt_vld[k] <= 1'b0;
            end
            for (int k = 0; k < NUM_MSG_IDS; k++) begin
                r_rt_cnt[k] <= '0;
            end
        end else begin
            if (i_dcmd.sub_write) begin
                r_rt_vld[w_wr_addr] <= 1'b1;
                r_rt_cnt[w_iidx]    <= r_rt_cnt[w_iidx] + SCW'(1);
            end else if (i_dcmd.unsub_clear) begin
                r_rt_vld[w_wr_addr] <= 1'b0;
                r_rt_cnt[w_iidx]    <= r_rt_cnt[w_iidx] - SCW'(1);
            end
        end
    end

    // Queue store: written at the tail, read at the head.
    always_ff @(posedge i_clk) begin
        if (i_dcmd.enqueue) begin
            r_q_mem[{w_qidx, r_tail[w_qidx]}] <= r_h;
        end
        r_q_rd <= r_q_mem[{w_qidx, r_head[w_qidx]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PIPES; k++) begin
                r_head[k]   <= '0;
                r_tail[k]   <= '0;
                r_fill[k]   <= '0;
                r_active[k] <= 1'b0;
            end
        end else begin
            if (i_dcmd.sub_write) begin
                r_active[w_sidx] <= 1'b1;
            end
            if (i_dcmd.enqueue) begin
                r_tail[w_qidx] <= (r_tail[w_qidx] == LAST_QPOS) ? '0
                                  : r_tail[w_qidx] + QW'(1);
                r_fill[w_qidx] <= r_fill[w_qidx] + FW'(1);
            end else if (i_dcmd.pop) begin
                r_head[w_qidx] <= (r_head[w_qidx] == LAST_QPOS) ? '0
                                  : r_head[w_qidx] + QW'(1);
                r_fill[w_qidx] <= r_fill[w_qidx] - FW'(1);
            end else if (i_dcmd.flush) begin
                r_head[w_qidx]   <= '0;
                r_tail[w_qidx]   <= '0;
                r_fill[w_qidx]   <= '0;
                r_active[w_qidx] <= 1'b0;
            end
        end
    end

    // Reference count memory with per-entry valid bits.
    always_ff @(posedge i_clk) begin
        r_ref_q <= r_ref_mem[w_ref_raddr];
        if (i_dcmd.pub_wb) begin
            r_ref_mem[r_h[HW-1:0]] <= r_ref_acc;
        end else if (i_dcmd.ref_dec && w_pop_ok && (w_ref_val != '0)) begin
            r_ref_mem[r_ohdl[HW-1:0]] <= w_ref_val - REFW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MSG_SLOTS; k++) begin
                r_ref_vld[k] <= 1'b0;
            end
            r_ref_vq <= 1'b0;
        end else begin
            r_ref_vq <= r_ref_vld[w_ref_raddr];
            if (i_dcmd.pub_wb) begin
                r_ref_vld[r_h[HW-1:0]] <= 1'b1;
            end
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.bus_en     = r_bus_en;
        o_sts.cmd        = r_cmd;
        o_sts.sub_ok     = w_sub_ok;
        o_sts.id_ok      = w_id_ok;
        o_sts.h_ok       = w_h_ok;
        o_sts.cnt_full   = (r_rt_cnt[w_iidx] >= SLOTS_C);
        o_sts.cnt_zero   = (r_rt_cnt[w_iidx] == '0);
        o_sts.q_active   = r_active[w_qidx];
        o_sts.q_empty    = (r_fill[w_qidx] == '0);
        o_sts.ref_nz     = (w_ref_val != '0);
        o_sts.ev_vld     = r_rd_vld;
        o_sts.ev_last    = (r_rd_slot == LAST_SLOT);
        o_sts.ev_match   = w_match;
        o_sts.ev_deliver = w_deliver;
        o_sts.have_empty = r_have_empty;
        o_sts.n_zero     = (r_n == '0);
        o_sts.out_free   = w_out_free;
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_o_status;
    assign o_out_handle = r_o_hdl;
    assign o_deliveries = r_o_dlv;

endmodule

`default_nettype wire
